// ----- hw/rtl/rfpa_pkg.sv -----
package rfpa_pkg;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned TS_W     = 32;
	localparam int unsigned GAIN_W   = 31;
	localparam int unsigned CFG_IW   = 3;
	localparam int unsigned CFG_DW   = 31;

	// bit-serial multiplier: 32 x 32, one multiplier bit a cycle
	localparam int unsigned MUL_W  = 32;
	localparam int unsigned MUL_CW = 5;

	// restoring divider: one quotient bit a cycle
	localparam int unsigned DIV_NW = 68;
	localparam int unsigned DIV_DW = 48;
	localparam int unsigned DIV_CW = 7;

	localparam logic [31:0] KP_COEF = 32'd2485691930;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

	localparam logic [CFG_IW-1:0] REG_VELOCITY_MODE = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CYCLES_NEEDED = 3'd1;
	localparam logic [CFG_IW-1:0] REG_AMP_TOL       = 3'd2;
	localparam logic [CFG_IW-1:0] REG_PER_TOL       = 3'd3;
	localparam logic [CFG_IW-1:0] REG_RELAY_HEIGHT  = 3'd4;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_NEG   = 2'd1,
		PH_POS   = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL_A,
		ST_MUL_P,
		ST_KP_MUL,
		ST_KP_DIV,
		ST_KI_DIV,
		ST_KD_MUL,
		ST_KD_DIV,
		ST_FIN
	} state_t;

	function automatic logic [GAIN_W-1:0] sat_gain(input logic [DIV_NW-1:0] v);
		if (v[DIV_NW-1:GAIN_W] != '0) begin
			return GAIN_MAX;
		end
		return v[GAIN_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/rfpa_if.sv -----
interface rfpa_meas_if;
	import rfpa_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TS_W-1:0]            timestamp;
	modport source (output valid, sample, timestamp, input ready);
	modport sink   (input valid, sample, timestamp, output ready);
endinterface

interface rfpa_result_if;
	import rfpa_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] effort;
	logic [1:0]                 phase;
	logic                       gains_valid;
	logic [TS_W-1:0]            cycle_period;
	logic [GAIN_W-1:0]          cycle_amplitude;
	logic [GAIN_W-1:0]          gain_p;
	logic [GAIN_W-1:0]          gain_i;
	logic [GAIN_W-1:0]          gain_d;
	modport source (output valid, effort, phase, gains_valid, cycle_period,
		cycle_amplitude, gain_p, gain_i, gain_d, input ready);
	modport sink   (input valid, effort, phase, gains_valid, cycle_period,
		cycle_amplitude, gain_p, gain_i, gain_d, output ready);
endinterface

// ----- hw/rtl/relay_feedback_pid_autotuner.sv -----
// relay feedback autotuner with tyreus-luyben gain rules
//
// meas channel: one request per control tick, carrying a signed q16.16
// sample and a wrapping tick timestamp. result channel: one request per
// measurement with the relay effort, the phase, the last cycle's period
// and amplitude, and the gains on the request where tuning completes.
// configuration: cfg_wr_en/cfg_index/cfg_wdata; the user must write it
// only while idle, which the block itself does not enforce.
// an ordinary sample is captured, evaluated and then written to the
// output register once it is free. a sample that closes an oscillation
// cycle runs two serial multiplies for the tolerance checks; the
// completing sample then adds two multiplies and up to three divisions.
// the serial multiplier and the restoring divider each work one bit per
// cycle.
// one measurement is worked on at a time; a new one is taken as soon as
// the previous result sits in the output register, even while the
// receiver stalls it. a stalled result holds until taken.
// reset: tuner in start phase, peaks and history at zero, registers at
// their defaults; no clearing pass is needed.
module relay_feedback_pid_autotuner (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rfpa_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rfpa_pkg::CFG_DW-1:0] cfg_wdata,
	rfpa_meas_if.sink                   meas,
	rfpa_result_if.source               result
);
	import rfpa_pkg::*;

	// configuration registers
	logic              vmode_q;
	logic [7:0]        needed_q;
	logic [15:0]       tol_a_q;
	logic [15:0]       tol_p_q;
	logic [GAIN_W-1:0] height_q;

	// tuner state
	state_t                     state_q, state_nx;
	phase_t                     phase_q;
	logic signed [SAMPLE_W-1:0] cross_q;
	logic signed [SAMPLE_W-1:0] high_q;
	logic signed [SAMPLE_W-1:0] low_q;
	logic [TS_W-1:0]            cstart_q;
	logic [TS_W-1:0]            pprev_q;
	logic [GAIN_W-1:0]          aprev_q;
	logic [7:0]                 mc_q;
	logic [TS_W-1:0]            hper_q;
	logic [GAIN_W-1:0]          hamp_q;
	logic                       gv_q;
	logic                       amp_ok_q;
	logic                       issued_q;
	logic [GAIN_W-1:0]          kp_q;
	logic [GAIN_W-1:0]          ki_q;
	logic [GAIN_W-1:0]          kd_q;

	// captured request
	logic signed [SAMPLE_W-1:0] s_q;
	logic [TS_W-1:0]            ts_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_eff_q;
	logic [1:0]                 out_phase_q;
	logic                       out_gv_q;
	logic [TS_W-1:0]            out_per_q;
	logic [GAIN_W-1:0]          out_amp_q;
	logic [GAIN_W-1:0]          out_kp_q;
	logic [GAIN_W-1:0]          out_ki_q;
	logic [GAIN_W-1:0]          out_kd_q;

	// shared arithmetic units
	logic                mul_start, mul_done;
	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [2*MUL_W-1:0]  mul_prod;
	logic                div_start, div_done;
	logic [DIV_NW-1:0]   div_n;
	logic [DIV_DW-1:0]   div_d;
	logic [DIV_NW-1:0]   div_q;

	rfpa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	rfpa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .done(div_done), .quotient(div_q)
	);

	// evaluation of the captured sample
	logic                       start_ph;
	phase_t                     ph0;
	logic signed [SAMPLE_W-1:0] cross_e, hp_e, lp_e, xlvl;
	logic                       closing, falling;
	logic signed [SAMPLE_W:0]   pk_diff;
	logic [GAIN_W-1:0]          amp;

	assign start_ph = (phase_q == PH_START);
	assign ph0      = start_ph ? PH_NEG : phase_q;
	// position mode latches the first sample as crossing level and peaks
	assign cross_e  = (start_ph && !vmode_q) ? s_q : cross_q;
	assign hp_e     = (start_ph && !vmode_q) ? s_q : high_q;
	assign lp_e     = (start_ph && !vmode_q) ? s_q : low_q;
	assign xlvl     = vmode_q ? '0 : cross_e;
	assign closing  = (ph0 == PH_NEG) && (s_q > xlvl);
	assign falling  = (ph0 == PH_POS) && (s_q < xlvl);
	assign pk_diff  = {hp_e[SAMPLE_W-1], hp_e} - {lp_e[SAMPLE_W-1], lp_e};
	// half peak-to-peak, zero when the swing is not positive
	assign amp      = (!pk_diff[SAMPLE_W] && pk_diff != '0) ? pk_diff[SAMPLE_W-1:1] : '0;

	// match tests: |cur - prev| * 2^16 < tol * prev
	logic [GAIN_W-1:0] d_amp;
	logic [TS_W-1:0]   d_per;
	logic              amp_ok, per_ok, ok;
	logic [7:0]        mc_inc, mc_new;
	logic              complete;

	assign d_amp    = (hamp_q > aprev_q) ? hamp_q - aprev_q : aprev_q - hamp_q;
	assign d_per    = (hper_q > pprev_q) ? hper_q - pprev_q : pprev_q - hper_q;
	assign amp_ok   = {17'd0, d_amp, 16'd0} < mul_prod;
	assign per_ok   = {16'd0, d_per, 16'd0} < mul_prod;
	assign ok       = amp_ok_q && per_ok;
	assign mc_inc   = (mc_q == 8'hFF) ? mc_q : mc_q + 8'd1;
	assign mc_new   = ok ? mc_inc : 8'd0;
	assign complete = ok && (mc_new >= needed_q);

	// gain operands
	logic [34:0] kp_x9;
	logic [36:0] per_x20;
	logic [66:0] q_x10;

	assign kp_x9   = {1'b0, kp_q, 3'b0} + 35'(kp_q);
	assign per_x20 = {1'b0, hper_q, 4'b0} + {3'b0, hper_q, 2'b0};
	assign q_x10   = {1'b0, mul_prod[62:0], 3'b0} + {3'b0, mul_prod[62:0], 1'b0};

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (meas.valid) state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				state_nx = closing ? ST_MUL_A : ST_FIN;
			end
			ST_MUL_A: begin
				if (mul_done) state_nx = ST_MUL_P;
			end
			ST_MUL_P: begin
				if (mul_done) state_nx = complete ? ST_KP_MUL : ST_FIN;
			end
			ST_KP_MUL: begin
				if (mul_done) state_nx = (hamp_q == '0) ? ST_KI_DIV : ST_KP_DIV;
			end
			ST_KP_DIV: begin
				if (div_done) state_nx = ST_KI_DIV;
			end
			ST_KI_DIV: begin
				if (hper_q == '0 || div_done) state_nx = ST_KD_MUL;
			end
			ST_KD_MUL: begin
				if (mul_done) state_nx = ST_KD_DIV;
			end
			ST_KD_DIV: begin
				if (div_done) state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// unit issue and operand selection
	always_comb begin
		mul_start  = 1'b0;
		div_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_n      = '0;
		div_d      = '0;
		meas.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				meas.ready = 1'b1;
			end
			ST_MUL_A: begin
				mul_start = !issued_q;
				mul_a     = {16'd0, tol_a_q};
				mul_b     = {1'b0, aprev_q};
			end
			ST_MUL_P: begin
				mul_start = !issued_q;
				mul_a     = {16'd0, tol_p_q};
				mul_b     = pprev_q;
			end
			ST_KP_MUL: begin
				mul_start = !issued_q;
				mul_a     = {1'b0, height_q};
				mul_b     = KP_COEF;
			end
			ST_KP_DIV: begin
				div_start = !issued_q;
				div_n     = {5'd0, mul_prod[62:0]};
				div_d     = {1'b0, hamp_q, 16'd0};
			end
			ST_KI_DIV: begin
				div_start = !issued_q && (hper_q != '0);
				div_n     = DIV_NW'(kp_x9);
				div_d     = DIV_DW'(per_x20);
			end
			ST_KD_MUL: begin
				mul_start = !issued_q;
				mul_a     = {1'b0, kp_q};
				mul_b     = hper_q;
			end
			ST_KD_DIV: begin
				div_start = !issued_q;
				div_n     = {1'b0, q_x10};
				div_d     = 48'd63;
			end
			default: begin
			end
		endcase
	end

	assign result.valid           = out_valid_q;
	assign result.effort          = out_eff_q;
	assign result.phase           = out_phase_q;
	assign result.gains_valid     = out_gv_q;
	assign result.cycle_period    = out_per_q;
	assign result.cycle_amplitude = out_amp_q;
	assign result.gain_p          = out_kp_q;
	assign result.gain_i          = out_ki_q;
	assign result.gain_d          = out_kd_q;

	// control and tuner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vmode_q     <= 1'b0;
			needed_q    <= 8'd3;
			tol_a_q     <= 16'd6554;
			tol_p_q     <= 16'd6554;
			height_q    <= 31'd65536;
			phase_q     <= PH_START;
			cross_q     <= '0;
			high_q      <= '0;
			low_q       <= '0;
			cstart_q    <= '0;
			pprev_q     <= '0;
			aprev_q     <= '0;
			mc_q        <= '0;
			hper_q      <= '0;
			hamp_q      <= '0;
			gv_q        <= 1'b0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VELOCITY_MODE: vmode_q  <= cfg_wdata[0];
					REG_CYCLES_NEEDED: needed_q <= cfg_wdata[7:0];
					REG_AMP_TOL:       tol_a_q  <= cfg_wdata[15:0];
					REG_PER_TOL:       tol_p_q  <= cfg_wdata[15:0];
					REG_RELAY_HEIGHT:  height_q <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end

			if (state_q == ST_EVAL) begin
				gv_q    <= 1'b0;
				cross_q <= cross_e;
				if (phase_q == PH_DONE) begin
					// done: phase, peaks and timing hold
				end else if (closing) begin
					phase_q  <= PH_POS;
					hper_q   <= ts_q - cstart_q;
					hamp_q   <= amp;
					cstart_q <= ts_q;
					high_q   <= s_q;
					low_q    <= xlvl;
				end else if (falling) begin
					phase_q <= PH_NEG;
					high_q  <= hp_e;
					low_q   <= (s_q < lp_e) ? s_q : lp_e;
				end else if (ph0 == PH_POS) begin
					phase_q <= ph0;
					high_q  <= (s_q > hp_e) ? s_q : hp_e;
					low_q   <= lp_e;
				end else begin
					phase_q <= ph0;
					high_q  <= hp_e;
					low_q   <= (s_q < lp_e) ? s_q : lp_e;
				end
			end

			// period test done: update history and match count
			if (state_q == ST_MUL_P && mul_done) begin
				aprev_q <= hamp_q;
				pprev_q <= hper_q;
				mc_q    <= mc_new;
				if (complete) begin
					phase_q <= PH_DONE;
					gv_q    <= 1'b1;
				end
			end

			if (state_q == ST_FIN && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (meas.valid && meas.ready) begin
			s_q  <= meas.sample;
			ts_q <= meas.timestamp;
		end
		if (state_q == ST_MUL_A && mul_done) begin
			amp_ok_q <= amp_ok;
		end
		if (state_q == ST_KP_MUL && mul_done && hamp_q == '0) begin
			kp_q <= GAIN_MAX;
		end
		if (state_q == ST_KP_DIV && div_done) begin
			kp_q <= sat_gain(div_q);
		end
		if (state_q == ST_KI_DIV) begin
			if (hper_q == '0) begin
				ki_q <= (kp_q == '0) ? '0 : GAIN_MAX;
			end else if (div_done) begin
				ki_q <= sat_gain(div_q);
			end
		end
		if (state_q == ST_KD_DIV && div_done) begin
			kd_q <= sat_gain(div_q);
		end
		if (state_q == ST_FIN && (!out_valid_q || result.ready)) begin
			case (phase_q)
				PH_POS:  out_eff_q <= -$signed({1'b0, height_q});
				PH_NEG:  out_eff_q <= $signed({1'b0, height_q});
				default: out_eff_q <= '0;
			endcase
			out_phase_q <= phase_q;
			out_gv_q    <= gv_q;
			out_per_q   <= hper_q;
			out_amp_q   <= hamp_q;
			out_kp_q    <= gv_q ? kp_q : '0;
			out_ki_q    <= gv_q ? ki_q : '0;
			out_kd_q    <= gv_q ? kd_q : '0;
		end
	end

endmodule

// ----- hw/rtl/rfpa_mul.sv -----
module rfpa_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rfpa_pkg::MUL_W-1:0]       a,
	input  logic [rfpa_pkg::MUL_W-1:0]       b,
	output logic                             done,
	output logic [2*rfpa_pkg::MUL_W-1:0]     prod
);
	import rfpa_pkg::*;

	logic [MUL_W-1:0]   a_q;
	logic [2*MUL_W-1:0] p_q;
	logic [MUL_CW-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     sum;

	// add the multiplicand to the upper half when the low bit is set
	assign sum  = {1'b0, p_q[2*MUL_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CW'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_W-1:1]};
		end
	end

endmodule

// ----- hw/rtl/rfpa_div.sv -----
module rfpa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rfpa_pkg::DIV_NW-1:0] dividend,
	input  logic [rfpa_pkg::DIV_DW-1:0] divisor,
	output logic                        done,
	output logic [rfpa_pkg::DIV_NW-1:0] quotient
);
	import rfpa_pkg::*;

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign shifted  = {r_q, n_q[DIV_NW-1]};
	assign ge       = shifted >= {1'b0, d_q};
	assign diff     = shifted - {1'b0, d_q};
	assign done     = done_q;
	assign quotient = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_NW-2:0], ge};
			r_q <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
		end
	end

endmodule

// ----- bench/relay_feedback_pid_autotuner_chk.sv -----
module relay_feedback_pid_autotuner_chk
	import rfpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata,
	rfpa_meas_if              meas,
	rfpa_result_if            result,
	output int                fails,
	output int                waiting
);

	typedef struct packed {
		logic signed [31:0] effort;
		logic [1:0]         phase;
		logic               gains_valid;
		logic [31:0]        period;
		logic [30:0]        amplitude;
		logic [30:0]        kp;
		logic [30:0]        ki;
		logic [30:0]        kd;
	} tune_out_t;

	localparam longint unsigned SAT = 64'h7FFF_FFFF;

	tune_out_t due_q[$];

	// register copies
	logic        vel_mode;
	logic [7:0]  need_cycles;
	logic [15:0] amp_tol, per_tol;
	logic [30:0] height;

	// tuner copy
	phase_t      ph;
	longint      cross_lvl, hi_pk, lo_pk;
	logic [31:0] start_ts, last_per, last_amp, held_per;
	logic [30:0] held_amp;
	logic [7:0]  match_cnt;

	function automatic longint unsigned clip(input longint unsigned v);
		return (v > SAT) ? SAT : v;
	endfunction

	function automatic bit close_to(input longint unsigned cur, input longint unsigned prv,
		input longint unsigned tol);
		longint unsigned d;
		d = (cur > prv) ? cur - prv : prv - cur;
		return (d << 16) < tol * prv;
	endfunction

	function tune_out_t tune_step(input logic signed [31:0] smp, input logic [31:0] ts);
		tune_out_t o;
		longint s, lvl, diff;
		logic [31:0] per, amp;
		longint unsigned kp, ki, kd, h, a, p, q;
		s = smp;
		o = '0;
		if (ph == PH_START) begin
			if (!vel_mode) begin
				cross_lvl = s;
				hi_pk = s;
				lo_pk = s;
			end
			ph = PH_NEG;
		end
		lvl = vel_mode ? 0 : cross_lvl;
		if (ph == PH_POS && s < lvl) begin
			ph = PH_NEG;
		end else if (ph == PH_NEG && s > lvl) begin
			per = ts - start_ts;
			diff = hi_pk - lo_pk;
			amp = (diff > 0) ? 32'(diff >>> 1) : 32'd0;
			ph = PH_POS;
			held_per = per;
			held_amp = amp[30:0];
			if (close_to(amp, last_amp, amp_tol) && close_to(per, last_per, per_tol)) begin
				if (match_cnt < 8'd255) match_cnt++;
				if (match_cnt >= need_cycles) begin
					ph = PH_DONE;
					o.gains_valid = 1'b1;
					h = height;
					a = held_amp;
					p = held_per;
					kp = (a == 0) ? SAT : clip((h * 64'(KP_COEF)) / (a << 16));
					if (p == 0) ki = (kp == 0) ? 0 : SAT;
					else ki = clip((kp * 9) / (20 * p));
					q = kp * p;
					kd = clip((q / 63) * 10 + ((q % 63) * 10) / 63);
					o.kp = kp[30:0];
					o.ki = ki[30:0];
					o.kd = kd[30:0];
				end
			end else begin
				match_cnt = '0;
			end
			hi_pk = lvl;
			lo_pk = lvl;
			start_ts = ts;
			last_per = per;
			last_amp = amp;
		end
		if (ph == PH_POS) begin
			if (s > hi_pk) hi_pk = s;
			o.effort = -$signed({1'b0, height});
		end else if (ph == PH_NEG) begin
			if (s < lo_pk) lo_pk = s;
			o.effort = $signed({1'b0, height});
		end
		o.phase = ph;
		o.period = held_per;
		o.amplitude = held_amp;
		return o;
	endfunction

	assign waiting = due_q.size();

	always @(posedge clk or negedge arst_n) begin
		tune_out_t got, want;
		if (!arst_n) begin
			vel_mode = 1'b0;
			need_cycles = 8'd3;
			amp_tol = 16'd6554;
			per_tol = 16'd6554;
			height = 31'd65536;
			ph = PH_START;
			cross_lvl = 0;
			hi_pk = 0;
			lo_pk = 0;
			start_ts = '0;
			last_per = '0;
			last_amp = '0;
			match_cnt = '0;
			held_per = '0;
			held_amp = '0;
			due_q.delete();
			fails = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_VELOCITY_MODE: vel_mode = cfg_wdata[0];
					REG_CYCLES_NEEDED: need_cycles = cfg_wdata[7:0];
					REG_AMP_TOL:       amp_tol = cfg_wdata[15:0];
					REG_PER_TOL:       per_tol = cfg_wdata[15:0];
					REG_RELAY_HEIGHT:  height = cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = '{result.effort, result.phase, result.gains_valid, result.cycle_period,
					result.cycle_amplitude, result.gain_p, result.gain_i, result.gain_d};
				if (due_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: effort/phase/gv/per/amp/kp/ki/kd", $time);
						$display("  expected %0d %0d %0d %0d %0d %0d %0d %0d", want.effort,
							want.phase, want.gains_valid, want.period, want.amplitude,
							want.kp, want.ki, want.kd);
						$display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d", got.effort,
							got.phase, got.gains_valid, got.period, got.amplitude,
							got.kp, got.ki, got.kd);
					end
				end
			end
			if (meas.valid && meas.ready) due_q.push_back(tune_step(meas.sample, meas.timestamp));
		end
	end

endmodule

// ----- bench/relay_feedback_pid_autotuner_tb.sv -----
module relay_feedback_pid_autotuner_tb;
	import rfpa_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;
	int                fails;
	int                waiting;

	rfpa_meas_if   meas();
	rfpa_result_if result();

	// stimulus controls: eager drops the sender's gaps, calm drops the receiver's
	bit          eager, calm, hold_req;
	logic [31:0] tick;
	int          centre;
	int          sent;

	relay_feedback_pid_autotuner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.meas      (meas),
		.result    (result)
	);

	relay_feedback_pid_autotuner_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.meas      (meas),
		.result    (result),
		.fails     (fails),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop, well beyond the slowest legal run
	initial begin
		#20000000;
		$display("relay_feedback_pid_autotuner: mismatch");
		$finish;
	end

	// one measurement request: random gap, then hold until taken
	task automatic send(input logic [31:0] smp, input logic [31:0] ts);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			meas.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		meas.valid = 1'b1;
		meas.sample = smp;
		meas.timestamp = ts;
		forever begin
			#1;
			if (meas.ready) break;
			@(negedge clk);
		end
		@(posedge clk);
		sent++;
	endtask

	// register write, only once every result is home and the block is quiet
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		meas.valid = 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// relay-like oscillation around the crossing level, with some jitter
	task automatic wave(input int cycles, input int amp, input int half, input int jit,
		input int step, input bit vel);
		longint lvl, s;
		int j;
		lvl = vel ? 0 : centre;
		for (int c = 0; c < cycles; c++) begin
			for (int k = 0; k < 2 * half; k++) begin
				j = (jit > 0) ? $urandom_range(0, jit) : 0;
				s = (k < half) ? lvl + amp - j : lvl - amp + j;
				tick += step;
				send(32'(s), tick);
			end
			// occasional timing slip to break up the period match
			if ($urandom_range(0, 7) == 0) tick += $urandom_range(1, 40);
		end
	endtask

	// unstructured requests: full-range samples and timestamps
	task automatic noise(input int n);
		for (int k = 0; k < n; k++) begin
			tick += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
			send($urandom, tick);
		end
	endtask

	// result side: random stalls per request, and the long hold-off on demand
	initial begin
		int st;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			st = calm ? 0 : $urandom_range(0, 5);
			@(negedge clk);
			if (st > 0) begin
				result.ready = 1'b0;
				repeat (st) @(negedge clk);
			end
			if (hold_req) begin
				result.ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			result.ready = 1'b1;
			forever begin
				#1;
				if (result.valid) break;
				@(negedge clk);
			end
			@(posedge clk);
			if ($urandom_range(0, 60) == 0) calm = ~calm;
		end
	end

	initial begin
		int budget, step, amp, half;
		bit vel;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		meas.valid = 1'b0;
		meas.sample = '0;
		meas.timestamp = '0;
		eager = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		tick = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// keep the tuner from finishing early: completion is final until reset
		write_reg(REG_CYCLES_NEEDED, 31'd255);
		write_reg(REG_VELOCITY_MODE, 31'd0);

		// directed: first sample sets the crossing level in position mode
		centre = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
		send(centre, tick);
		send(centre, tick + 1);          // equal to the level: no crossing
		send(32'h8000_0000, 32'hFFFF_FFFF);
		send(32'h7FFF_FFFF, 32'h0000_0000);  // closes a cycle across the wrap
		send(centre - 1, 32'h0000_0001);
		send(centre + 1, 32'h0000_0002);
		send(32'h8000_0000, 32'h0000_0003);
		send(32'h0000_0000, 32'hFFFF_FFFE);
		send(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		tick = 32'hFFFF_FFF0;
		wave(3, 32'h0000_4000, 2, 0, 1, 1'b0);   // timestamps close to the wrap

		// random phases under varied settings
		for (int ph = 0; ph < 8; ph++) begin
			vel = ph[0];
			write_reg(REG_VELOCITY_MODE, 31'(vel));
			write_reg(REG_AMP_TOL, (ph == 2) ? 31'd0 : (ph == 3) ? 31'd65535 : 31'($urandom_range(0, 65535)));
			write_reg(REG_PER_TOL, (ph == 2) ? 31'd0 : (ph == 3) ? 31'd65535 : 31'($urandom_range(0, 65535)));
			write_reg(REG_RELAY_HEIGHT, (ph == 4) ? 31'd0 : (ph == 5) ? 31'h7FFF_FFFF : 31'($urandom));
			write_reg(REG_CYCLES_NEEDED, 31'd255);
			eager = $urandom_range(0, 2) == 0;
			// one long receiver hold-off while requests keep coming
			if (ph == 3) hold_req = 1'b1;
			budget = sent + 190;
			while (sent < budget) begin
				if ($urandom_range(0, 3) == 0) begin
					noise($urandom_range(1, 8));
				end else begin
					step = $urandom_range(1, 3);
					amp = (1 << $urandom_range(4, 28)) + $urandom_range(0, 255);
					half = $urandom_range(1, 6);
					wave($urandom_range(2, 6), amp, half, amp / 32, step, vel);
				end
			end
		end

		// completion: zero cycles needed still takes one matching cycle
		write_reg(REG_VELOCITY_MODE, 31'd0);
		write_reg(REG_AMP_TOL, 31'd65535);
		write_reg(REG_PER_TOL, 31'd65535);
		write_reg(REG_RELAY_HEIGHT, 31'($urandom));
		write_reg(REG_CYCLES_NEEDED, 31'd0);
		eager = 1'b0;
		wave(6, 32'h0002_0000 + $urandom_range(0, 32'hFFFF), 4, 0, 1, 1'b0);
		noise(30);

		// drain, then allow for the longest internal pass
		@(negedge clk);
		meas.valid = 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (fails == 0) begin
			$display("relay_feedback_pid_autotuner: match");
		end else begin
			$display("relay_feedback_pid_autotuner: mismatch");
		end
		$finish;
	end

endmodule
